// ===== design/const_color_pixel_blend_unit_top_assert.svh =====
// assertion macros for the constant color pixel blend unit
`ifndef CONST_COLOR_PIXEL_BLEND_UNIT_TOP_ASSERT_SVH
`define CONST_COLOR_PIXEL_BLEND_UNIT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CCPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccpb assertion failed");
// next-cycle implication
`define CCPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccpb assertion failed");
`else
`define CCPB_ASSERT_NOW(lbl, ante, cons)
`define CCPB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/ccpb_pkg.sv =====
// shared types, codes and a helper function for the pixel blend unit
package ccpb_pkg;

  localparam int unsigned PIX_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [2:0] MODE_FILL   = 3'd0;
  localparam logic [2:0] MODE_COLOR  = 3'd1;
  localparam logic [2:0] MODE_ALPHA  = 3'd2;
  localparam logic [2:0] MODE_BLEND  = 3'd3;
  localparam logic [2:0] MODE_PREMUL = 3'd4;
  localparam logic [2:0] MODE_MATTE  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FILL  = 2'd3;

  typedef struct packed {
    logic [2:0]       op_mode;
    logic [PIX_W-1:0] const_color;
    logic [7:0]       opacity;
    logic [7:0]       alpha_fill;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blend;
    logic [7:0] premul;
    logic [7:0] matte;
  } lane_res_t;

  // d - (d*o)>>8 + src, clipped at 255; o is at most 256 so the subtract never wraps
  function automatic logic [7:0] premul_mix(logic [7:0] d, logic [8:0] o, logic [8:0] src);
    logic [16:0] dprod;
    logic [8:0]  dsub;
    logic [9:0]  sum;
    dprod = {9'd0, d} * {8'd0, o};
    dsub  = {1'b0, d} - dprod[16:8];
    sum   = {1'b0, dsub} + {1'b0, src};
    return (sum > 10'd255) ? 8'hff : sum[7:0];
  endfunction

endpackage

// ===== design/ccpb_cfg_regs.sv =====
// configuration register file
module ccpb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ccpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccpb_pkg::PIX_W-1:0]     cfg_wdata,
  output ccpb_pkg::cfg_t                 cfg
);
  import ccpb_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.op_mode     <= MODE_FILL;
      cfg_r.const_color <= '0;
      cfg_r.opacity     <= 8'hff;
      cfg_r.alpha_fill  <= 8'hff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OP_MODE:     cfg_r.op_mode     <= cfg_wdata[2:0];
        REG_CONST_COLOR: cfg_r.const_color <= cfg_wdata;
        REG_OPACITY:     cfg_r.opacity     <= cfg_wdata[7:0];
        REG_ALPHA_FILL:  cfg_r.alpha_fill  <= cfg_wdata[7:0];
        default:         cfg_r.op_mode     <= cfg_r.op_mode;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/ccpb_lane.sv =====
// one color channel: blend, premultiplied blend and matte results
module ccpb_lane (
  input  logic                  [7:0] d,
  input  logic                  [7:0] c,
  input  logic                  [7:0] opa,
  input  logic                  [8:0] o,
  input  logic                  [7:0] a,
  output ccpb_pkg::lane_res_t         res
);
  import ccpb_pkg::*;

  logic        [7:0]  inv;
  logic        [15:0] blend_sum;
  logic        [16:0] cprod;
  logic signed [8:0]  diff;
  logic signed [17:0] mprod;
  logic signed [9:0]  q;
  logic signed [10:0] mv;

  always_comb begin
    inv       = 8'd255 - opa;
    // max 255*255, fits 16 bits
    blend_sum = ({8'd0, d} * {8'd0, inv}) + ({8'd0, c} * {8'd0, opa});
    res.blend = blend_sum[15:8];

    cprod      = {9'd0, c} * {8'd0, o};
    res.premul = premul_mix(d, o, cprod[16:8]);

    // dropping the low byte of a two's complement product floors it
    diff  = $signed({1'b0, d}) - $signed({1'b0, c});
    mprod = diff * $signed({1'b0, a});
    q     = mprod[17:8];
    mv    = $signed({3'b000, c}) + $signed({q[9], q});
    if (mv[10]) begin
      res.matte = 8'h00;
    end else if (mv > 11'sd255) begin
      res.matte = 8'hff;
    end else begin
      res.matte = mv[7:0];
    end
  end

endmodule

// ===== design/ccpb_datapath.sv =====
// per-pixel datapath: three color lanes, alpha lane and mode select
module ccpb_datapath (
  input  logic [ccpb_pkg::PIX_W-1:0] pix,
  input  ccpb_pkg::cfg_t             cfg,
  output logic [ccpb_pkg::PIX_W-1:0] result
);
  import ccpb_pkg::*;

  logic [8:0]  o;
  logic [7:0]  alpha_premul;
  lane_res_t   lres [3];
  logic [23:0] blend_rgb;
  logic [23:0] premul_rgb;
  logic [23:0] matte_rgb;

  assign o = {1'b0, cfg.opacity} + {8'd0, cfg.opacity[7]};

  for (genvar k = 0; k < 3; k++) begin : g_lane
    ccpb_lane u_lane (
      .d   (pix[8*k +: 8]),
      .c   (cfg.const_color[8*k +: 8]),
      .opa (cfg.opacity),
      .o   (o),
      .a   (pix[31:24]),
      .res (lres[k])
    );
    assign blend_rgb[8*k +: 8]  = lres[k].blend;
    assign premul_rgb[8*k +: 8] = lres[k].premul;
    assign matte_rgb[8*k +: 8]  = lres[k].matte;
  end

  // alpha lane adds the opacity itself
  assign alpha_premul = premul_mix(pix[31:24], o, {1'b0, cfg.opacity});

  always_comb begin
    unique case (cfg.op_mode)
      MODE_FILL:   result = cfg.const_color;
      MODE_COLOR:  result = {pix[31:24], cfg.const_color[23:0]};
      MODE_ALPHA:  result = {cfg.alpha_fill, pix[23:0]};
      MODE_BLEND:  result = {pix[31:24], blend_rgb};
      MODE_PREMUL: result = {alpha_premul, premul_rgb};
      MODE_MATTE:  result = {8'hff, matte_rgb};
      default:     result = pix;
    endcase
  end

endmodule

// ===== design/const_color_pixel_blend_unit_top.sv =====
// top level of the constant color pixel blend unit
//
// Takes one ARGB8888 pixel per beat on the in_ channel and returns one result
// pixel per beat on the out_ channel, with the span end mark carried along.
// The operation (fill, color replace, alpha replace, blend, premultiplied
// blend, matte) and its constant color, opacity and alpha byte come from
// registers written through the cfg_ port; write them only while no pixel is
// in flight.
// Throughput is one pixel per clock while out_ready stays high: an input register
// feeds the per-lane multiply and select logic, which loads the output register.
// When the receiver holds out_ready low the output register keeps its pixel,
// the input register fills behind it, and in_ready drops only once both hold
// a pixel.
// Reset (rst_n low, synchronous) empties both stages and loads the registers
// with fill mode, color 0, opacity 255 and alpha byte 255.
`include "const_color_pixel_blend_unit_top_assert.svh"
module const_color_pixel_blend_unit_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ccpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccpb_pkg::PIX_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ccpb_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic                           in_span_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ccpb_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                           out_span_end_out
);
  import ccpb_pkg::*;

  cfg_t             cfg;
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_end_r;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_end_r;
  logic [PIX_W-1:0] result;
  logic             in_fire;
  logic             s1_adv;

  ccpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccpb_datapath u_dp (
    .pix    (s1_pix_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    s1_adv        = s1_valid_r && (!out_valid_r || out_ready);
    in_ready      = !s1_valid_r || s1_adv;
    in_fire       = in_valid && in_ready;
    s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= in_pixel_in;
      s1_end_r <= in_span_end;
    end
    if (s1_adv) begin
      out_pix_r <= result;
      out_end_r <= s1_end_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pix_r;
  assign out_span_end_out = out_end_r;

  `CCPB_ASSERT_NOW(a_empty_stage_ready, !s1_valid_r, in_ready)
  `CCPB_ASSERT_NEXT(a_accept_fills_stage, in_valid && in_ready, s1_valid_r)
  `CCPB_ASSERT_NEXT(a_stage_moves_to_free_out, s1_valid_r && !out_valid_r, out_valid_r)
  `CCPB_ASSERT_NEXT(a_fill_gives_color, s1_adv && (cfg.op_mode == MODE_FILL),
                    out_pixel_out == $past(cfg.const_color))

endmodule

// ===== sim/const_color_pixel_blend_unit_top_tb.sv =====
// testbench for the constant color pixel blend unit: predicted results checked beat by beat
module const_color_pixel_blend_unit_top_tb;
  import ccpb_pkg::*;

  // op_mode codes with no operation behind them, the pixel passes through
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             span_end;
  } pixel_beat_t;

  class pixel_blend_scoreboard;
    pixel_beat_t      expected_q[$];
    logic [2:0]       mode;
    logic [PIX_W-1:0] color;
    logic [7:0]       opa;
    logic [7:0]       afill;
    int               errors;

    function new();
      mode   = MODE_FILL;
      color  = '0;
      opa    = 8'hff;
      afill  = 8'hff;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
      case (idx)
        REG_OP_MODE:     mode  = data[2:0];
        REG_CONST_COLOR: color = data;
        REG_OPACITY:     opa   = data[7:0];
        REG_ALPHA_FILL:  afill = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] blended_pixel(logic [PIX_W-1:0] d);
      logic [PIX_W-1:0] r;
      int k, dl, cl, v, o, a;
      o = opa + (opa >> 7);
      a = d[31:24];
      r = d;
      case (mode)
        MODE_FILL:  r = color;
        MODE_COLOR: r = {d[31:24], color[23:0]};
        MODE_ALPHA: r = {afill, d[23:0]};
        MODE_BLEND: begin
          for (k = 0; k < 3; k++) begin
            dl = d[8*k +: 8];
            cl = color[8*k +: 8];
            v = (dl * (255 - int'(opa)) + cl * int'(opa)) >> 8;
            r[8*k +: 8] = v[7:0];
          end
        end
        MODE_PREMUL: begin
          for (k = 0; k < 4; k++) begin
            dl = d[8*k +: 8];
            cl = color[8*k +: 8];
            // alpha lane adds the opacity itself instead of a scaled color
            v = dl - ((dl * o) >> 8) + ((k == 3) ? int'(opa) : ((cl * o) >> 8));
            if (v > 255) v = 255;
            r[8*k +: 8] = v[7:0];
          end
        end
        MODE_MATTE: begin
          r[31:24] = 8'hff;
          for (k = 0; k < 3; k++) begin
            dl = d[8*k +: 8];
            cl = color[8*k +: 8];
            // arithmetic shift floors toward minus infinity
            v = cl + (((dl - cl) * a) >>> 8);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            r[8*k +: 8] = v[7:0];
          end
        end
        default: r = d;
      endcase
      return r;
    endfunction

    function void note_pixel_in(logic [PIX_W-1:0] px, logic se);
      pixel_beat_t b;
      b.pixel    = blended_pixel(px);
      b.span_end = se;
      expected_q.push_back(b);
    endfunction

    function void check_pixel_out(logic [PIX_W-1:0] px, logic se);
      pixel_beat_t exp_b;
      if (expected_q.size() == 0) begin
        $display("%0t: output beat with nothing pending, pixel %h span_end %b", $time, px, se);
        errors++;
        return;
      end
      exp_b = expected_q.pop_front();
      if (px !== exp_b.pixel) begin
        $display("%0t: pixel_out expected %h actual %h", $time, exp_b.pixel, px);
        errors++;
      end
      if (se !== exp_b.span_end) begin
        $display("%0t: span_end_out expected %b actual %b", $time, exp_b.span_end, se);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PIX_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_in;
  logic                 in_span_end;
  logic                 out_valid;
  logic                 out_ready;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_span_end_out;

  pixel_blend_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  const_color_pixel_blend_unit_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_in      (in_pixel_in),
    .in_span_end      (in_span_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_out    (out_pixel_out),
    .out_span_end_out (out_span_end_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  // result side: check accepted beats, then pick ready for the next edge
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_pixel_out(out_pixel_out, out_span_end_out);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // junk above each narrow register's width must be dropped
  task automatic apply_config(logic [2:0] mode, logic [PIX_W-1:0] color, logic [7:0] opa,
                              logic [7:0] afill);
    write_reg(REG_OP_MODE, ($urandom() & 32'hffff_fff8) | mode);
    write_reg(REG_CONST_COLOR, color);
    write_reg(REG_OPACITY, ($urandom() & 32'hffff_ff00) | opa);
    write_reg(REG_ALPHA_FILL, ($urandom() & 32'hffff_ff00) | afill);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic se);
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    in_span_end <= se;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel_in(px, se);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    int k;
    p = $urandom();
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(3))
        0: p[8*k +: 8] = 8'h00;
        1: p[8*k +: 8] = 8'hff;
        default: ;
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] rand_opacity();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_stream(int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_pixel(rand_pixel(), ($urandom_range(7) == 0));
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  endtask

  initial begin
    int ph, chunk;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_pixel_in    <= '0;
    in_span_end    <= 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values straight out of reset
    send_pixel(32'hffff_ffff, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    drain();

    apply_config(MODE_FILL, 32'hffff_ffff, 8'h00, 8'h00);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hffff_ffff, 1'b1);
    drain();
    apply_config(MODE_COLOR, 32'h1234_5678, 8'hff, 8'hff);
    send_pixel(32'hff00_0000, 1'b1);
    send_pixel(32'h00ff_ffff, 1'b0);
    drain();
    apply_config(MODE_ALPHA, 32'h0000_0000, 8'hff, 8'h00);
    send_pixel(32'hffff_ffff, 1'b0);
    send_pixel(32'h00a5_5a0f, 1'b1);
    drain();
    // blend at both ends of the opacity range
    apply_config(MODE_BLEND, 32'h00ff_00ff, 8'h00, 8'hff);
    send_pixel(32'hffff_ffff, 1'b0);
    drain();
    apply_config(MODE_BLEND, 32'hffff_ffff, 8'hff, 8'hff);
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'hffff_ffff, 1'b0);
    drain();
    // premultiplied: full opacity saturates, 128 crosses into the rounding term
    apply_config(MODE_PREMUL, 32'hffff_ffff, 8'hff, 8'h00);
    send_pixel(32'hffff_ffff, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    drain();
    apply_config(MODE_PREMUL, 32'h80ff_4000, 8'h80, 8'h00);
    send_pixel(32'h8080_8080, 1'b0);
    drain();
    // matte: zero alpha gives the color, full alpha with negative differences
    apply_config(MODE_MATTE, 32'hff00_ff80, 8'h00, 8'h00);
    send_pixel(32'h00ff_ffff, 1'b0);
    send_pixel(32'hff00_0000, 1'b1);
    send_pixel(32'h80ff_0001, 1'b0);
    drain();
    apply_config(MODE_SPARE6, 32'hdead_beef, 8'h55, 8'haa);
    send_pixel(32'h1357_9bdf, 1'b1);
    drain();
    apply_config(MODE_SPARE7, 32'h0000_0000, 8'h00, 8'h00);
    send_pixel(32'hfedc_ba98, 1'b0);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (chunk = 0; chunk < 4; chunk++) begin
        apply_config(3'($urandom_range(7)), rand_pixel(), rand_opacity(),
                     8'($urandom_range(255)));
        // long receiver hold while the sender keeps offering, so the pipe backs up
        if (ph == 0 && chunk == 1)
          hold_req = 1'b1;
        send_stream(40);
        drain();
      end
    end

    repeat (4) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected beats never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
